// ===== rtl/defoc_pkg.sv =====
// ----------------------------------------------------------------------------
// defoc_pkg: shared types and constants
// Payload structs, configuration register indexes, controller commands and
// saturation helper for the dual-encoder voltage and velocity block.
// ----------------------------------------------------------------------------
package defoc_pkg;

  // One input request.
  typedef struct packed {
    logic        [15:0] raw_left;
    logic        [15:0] raw_right;
    logic signed [15:0] vq_left;
    logic signed [15:0] vq_rt;
  } in_t;

  // One result request.
  typedef struct packed {
    logic signed [15:0] phase_a_left;
    logic signed [15:0] phase_b_left;
    logic signed [15:0] phase_c_left;
    logic signed [15:0] phase_a_right;
    logic signed [15:0] phase_b_right;
    logic signed [15:0] phase_c_right;
    logic signed [31:0] velocity;
    logic               velocity_updated;
  } out_t;

  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = 16;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_OFFSET_LEFT  = 3'd0,
    REG_OFFSET_RIGHT = 3'd1,
    REG_POLE_COUNT   = 3'd2,
    REG_VEL_PERIOD   = 3'd3,
    REG_VEL_GAIN     = 3'd4
  } reg_idx_t;

  localparam logic [13:0] OFFSET_LEFT_RST  = 14'd7238;
  localparam logic [13:0] OFFSET_RIGHT_RST = 14'd4262;
  localparam logic [4:0]  POLE_COUNT_RST   = 5'd11;
  localparam logic [3:0]  VEL_PERIOD_RST   = 4'd10;
  localparam logic [15:0] VEL_GAIN_RST     = 16'd44;

  // sqrt(3)/2 in Q15.
  localparam logic signed [17:0] SQRT3_HALF_Q15 = 18'sd28378;

  // Multiplier operand selection.
  typedef enum logic [2:0] {
    MUL_NONE,
    MUL_ANG,
    MUL_SIN,
    MUL_COS,
    MUL_RB,
    MUL_VEL
  } mul_op_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ANG,
    ST_ADDR,
    ST_SIN,
    ST_COS,
    ST_RB,
    ST_PHS,
    ST_VEL,
    ST_FIL
  } state_t;

  typedef struct packed {
    logic    load_in;
    logic    side;
    mul_op_t mul_op;
    logic    m_wr;
    logic    phs_wr;
    logic    vel_commit;
  } cmd_t;

  typedef struct packed {
    logic out_free;
  } status_t;

  // Saturate a 48-bit signed value to 16 bits.
  function automatic logic signed [15:0] sat16(input logic signed [47:0] v);
    logic signed [15:0] r;
    if (v > 48'sd32767) r = 16'sh7FFF;
    else if (v < -48'sd32768) r = 16'sh8000;
    else r = v[15:0];
    return r;
  endfunction

endpackage

// ===== rtl/defoc_sine_rom.sv =====
// ----------------------------------------------------------------------------
// defoc_sine_rom: Q1.15 sine table
// Full-turn sine table built at elaboration, two registered read ports.
// ----------------------------------------------------------------------------
module defoc_sine_rom #(
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic [$clog2(DEPTH)-1:0] addr_a,
  input  logic [$clog2(DEPTH)-1:0] addr_b,
  output logic signed [15:0]       data_a,
  output logic signed [15:0]       data_b
);

  localparam int QUARTER = DEPTH / 4;
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

  typedef logic [63:0] u64_t;
  typedef logic signed [15:0] tab_t [DEPTH];

  // Restoring division, only used while the table is built.
  function automatic u64_t udiv(input u64_t num, input u64_t den);
    u64_t quo;
    u64_t rem;
    quo = '0;
    rem = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[62:0], num[b]};
      if (rem >= den) begin
        rem    = rem - den;
        quo[b] = 1'b1;
      end
    end
    return quo;
  endfunction

  // Taylor series in Q30, seven terms.
  function automatic tab_t build_tab();
    tab_t            t;
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint          sum;
    longint          v;
    int              q;
    int              j;
    for (int i = 0; i < DEPTH; i++) begin
      q = i / QUARTER;
      j = i % QUARTER;
      if (q % 2 == 1) j = QUARTER - j;
      x = (u64_t'(j) * HALF_PI_Q30) / QUARTER;
      x2 = (x * x) >> 30;
      term = x;
      sum = longint'(x);
      for (int k = 1; k <= 6; k++) begin
        term = udiv((term * x2) >> 30, u64_t'((2 * k) * (2 * k + 1)));
        if (k % 2 == 1) sum = sum - longint'(term);
        else sum = sum + longint'(term);
      end
      v = (sum + 64'sd16384) >>> 15;
      if (v > 64'sd32767) v = 64'sd32767;
      if (v < 64'sd0) v = 64'sd0;
      t[i] = (q >= 2) ? 16'(-v) : 16'(v);
    end
    return t;
  endfunction

  localparam tab_t TAB = build_tab();

  // Registered reads.
  always_ff @(posedge clk) begin
    data_a <= TAB[addr_a];
    data_b <= TAB[addr_b];
  end

endmodule

// ===== rtl/defoc_ctrl.sv =====
// ----------------------------------------------------------------------------
// defoc_ctrl: sequencing controller
// Steps the shared multiplier through both motors and the velocity update.
// ----------------------------------------------------------------------------
module defoc_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  defoc_pkg::status_t  status,
  output defoc_pkg::cmd_t     cmd
);

  defoc_pkg::state_t state, state_next;
  logic              side, side_next;

  // State and side registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= defoc_pkg::ST_IDLE;
      side  <= 1'b0;
    end else begin
      state <= state_next;
      side  <= side_next;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    side_next  = side;
    unique case (state)
      defoc_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_next = defoc_pkg::ST_ANG;
          side_next  = 1'b0;
        end
      end
      defoc_pkg::ST_ANG:  state_next = defoc_pkg::ST_ADDR;
      defoc_pkg::ST_ADDR: state_next = defoc_pkg::ST_SIN;
      defoc_pkg::ST_SIN:  state_next = defoc_pkg::ST_COS;
      defoc_pkg::ST_COS:  state_next = defoc_pkg::ST_RB;
      defoc_pkg::ST_RB:   state_next = defoc_pkg::ST_PHS;
      defoc_pkg::ST_PHS: begin
        if (side) begin
          state_next = defoc_pkg::ST_VEL;
        end else begin
          state_next = defoc_pkg::ST_ANG;
          side_next  = 1'b1;
        end
      end
      defoc_pkg::ST_VEL:  state_next = defoc_pkg::ST_FIL;
      defoc_pkg::ST_FIL: begin
        if (status.out_free) state_next = defoc_pkg::ST_IDLE;
      end
      default: state_next = defoc_pkg::ST_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    cmd        = '0;
    cmd.side   = side;
    cmd.mul_op = defoc_pkg::MUL_NONE;
    in_stall   = 1'b1;
    unique case (state)
      defoc_pkg::ST_IDLE: begin
        in_stall    = 1'b0;
        cmd.load_in = in_valid;
      end
      defoc_pkg::ST_ANG:  cmd.mul_op = defoc_pkg::MUL_ANG;
      defoc_pkg::ST_ADDR: cmd.mul_op = defoc_pkg::MUL_NONE;
      defoc_pkg::ST_SIN:  cmd.mul_op = defoc_pkg::MUL_SIN;
      defoc_pkg::ST_COS: begin
        cmd.mul_op = defoc_pkg::MUL_COS;
        cmd.m_wr   = 1'b1;
      end
      defoc_pkg::ST_RB:   cmd.mul_op = defoc_pkg::MUL_RB;
      defoc_pkg::ST_PHS:  cmd.phs_wr = 1'b1;
      defoc_pkg::ST_VEL:  cmd.mul_op = defoc_pkg::MUL_VEL;
      defoc_pkg::ST_FIL:  cmd.vel_commit = status.out_free;
      default: cmd = '0;
    endcase
  end

endmodule

// ===== rtl/defoc_dp.sv =====
// ----------------------------------------------------------------------------
// defoc_dp: datapath
// Configuration registers, shared multiplier, phase and velocity arithmetic,
// velocity state and the output register.
// ----------------------------------------------------------------------------
module defoc_dp #(
  parameter int ANGLE_BITS       = 14,
  parameter int SINE_TABLE_DEPTH = 1024
) (
  input  logic                                clk,
  input  logic                                rst,
  input  defoc_pkg::in_t                      in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output defoc_pkg::out_t                     out_data,
  input  logic                                cfg_we,
  input  logic [defoc_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [defoc_pkg::CFG_DATA_BITS-1:0] cfg_data,
  input  defoc_pkg::cmd_t                     cmd,
  output defoc_pkg::status_t                  status
);

  localparam int TB = $clog2(SINE_TABLE_DEPTH);
  localparam int AB = ANGLE_BITS;
  localparam logic [TB-1:0] QUARTER_OFS = TB'(SINE_TABLE_DEPTH / 4);
  localparam logic signed [AB+1:0] HALF = (AB+2)'(2 ** (AB - 1));
  localparam logic signed [AB+1:0] FULL = (AB+2)'(2 ** AB);

  // Configuration registers.
  logic [13:0] offset_left, offset_right;
  logic [4:0]  pole_count;
  logic [3:0]  velocity_period;
  logic [15:0] vel_gain;

  always_ff @(posedge clk) begin
    if (rst) begin
      offset_left     <= defoc_pkg::OFFSET_LEFT_RST;
      offset_right    <= defoc_pkg::OFFSET_RIGHT_RST;
      pole_count      <= defoc_pkg::POLE_COUNT_RST;
      velocity_period <= defoc_pkg::VEL_PERIOD_RST;
      vel_gain        <= defoc_pkg::VEL_GAIN_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        defoc_pkg::REG_OFFSET_LEFT:  offset_left     <= cfg_data[13:0];
        defoc_pkg::REG_OFFSET_RIGHT: offset_right    <= cfg_data[13:0];
        defoc_pkg::REG_POLE_COUNT:   pole_count      <= cfg_data[4:0];
        defoc_pkg::REG_VEL_PERIOD:   velocity_period <= cfg_data[3:0];
        defoc_pkg::REG_VEL_GAIN:     vel_gain        <= cfg_data;
        default: ;
      endcase
    end
  end

  // Input register.
  defoc_pkg::in_t in_reg;
  always_ff @(posedge clk) begin
    if (cmd.load_in) in_reg <= in_data;
  end

  // Angle counts from the byte-swapped words.
  logic [15:0]   swap_l, swap_r;
  logic [AB-1:0] count_l, count_r;
  assign swap_l  = {in_reg.raw_left[7:0], in_reg.raw_left[15:8]};
  assign swap_r  = {in_reg.raw_right[7:0], in_reg.raw_right[15:8]};
  assign count_l = swap_l[AB-1:0];
  assign count_r = swap_r[AB-1:0];

  // Side selection.
  logic [15:0]        ofs_diff;
  logic signed [16:0] vq_eff;
  assign ofs_diff = cmd.side ? (swap_r - 16'(offset_right)) : (swap_l - 16'(offset_left));
  assign vq_eff   = cmd.side ? 17'(in_reg.vq_rt) : -17'(in_reg.vq_left);

  // Shared multiplier with registered product.
  logic signed [50:0] prod;
  logic signed [32:0] mul_a;
  logic signed [17:0] mul_b;
  logic signed [15:0] sin_q, cos_q;
  logic signed [AB+1:0] dl, dr;
  logic signed [AB+2:0] dd;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.mul_op)
      defoc_pkg::MUL_ANG: begin
        mul_a = 33'($unsigned(ofs_diff[AB-1:0]));
        mul_b = 18'($unsigned(pole_count));
      end
      defoc_pkg::MUL_SIN: begin
        mul_a = 33'(vq_eff);
        mul_b = 18'(sin_q);
      end
      defoc_pkg::MUL_COS: begin
        mul_a = 33'(vq_eff);
        mul_b = 18'(cos_q);
      end
      defoc_pkg::MUL_RB: begin
        mul_a = prod[32:0];
        mul_b = defoc_pkg::SQRT3_HALF_Q15;
      end
      defoc_pkg::MUL_VEL: begin
        mul_a = 33'(dd);
        mul_b = 18'($unsigned(vel_gain));
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_op != defoc_pkg::MUL_NONE) prod <= mul_a * mul_b;
  end

  // Table index from the electrical angle held in the product.
  logic [AB-1:0]    elec;
  logic [AB+TB-1:0] idx_ext;
  logic [TB-1:0]    idx_sin, idx_cos;
  assign elec    = prod[AB-1:0];
  assign idx_ext = {elec, {TB{1'b0}}};
  assign idx_sin = idx_ext[AB+TB-1:AB];
  assign idx_cos = idx_sin + QUARTER_OFS;

  defoc_sine_rom #(.DEPTH(SINE_TABLE_DEPTH)) u_rom (
    .clk    (clk),
    .addr_a (idx_sin),
    .addr_b (idx_cos),
    .data_a (sin_q),
    .data_b (cos_q)
  );

  // vq * sin, kept for the phase step.
  logic signed [31:0] m_reg;
  always_ff @(posedge clk) begin
    if (cmd.m_wr) m_reg <= prod[31:0];
  end

  // Inverse Clarke with rounding half up and saturation.
  logic signed [47:0] half_a, rb, pa_w, pb_w, pc_w;
  assign half_a = 48'(m_reg) <<< 14;
  assign rb     = prod[47:0];
  assign pa_w   = (-48'(m_reg) + 48'sd16384) >>> 15;
  assign pb_w   = (half_a + rb + 48'sd536870912) >>> 30;
  assign pc_w   = (half_a - rb + 48'sd536870912) >>> 30;

  logic signed [15:0] pa_l, pb_l, pc_l, pa_r, pb_r, pc_r;
  always_ff @(posedge clk) begin
    if (cmd.phs_wr) begin
      if (cmd.side) begin
        pa_r <= defoc_pkg::sat16(pa_w);
        pb_r <= defoc_pkg::sat16(pb_w);
        pc_r <= defoc_pkg::sat16(pc_w);
      end else begin
        pa_l <= defoc_pkg::sat16(pa_w);
        pb_l <= defoc_pkg::sat16(pb_w);
        pc_l <= defoc_pkg::sat16(pc_w);
      end
    end
  end

  // Velocity state.
  logic [3:0]         tick_count;
  logic [AB-1:0]      last_angle_left, last_angle_right;
  logic signed [31:0] filtered_velocity;
  logic [3:0]         tick_next;
  logic               upd;
  logic signed [AB+1:0] rl, rr;

  assign rl = (AB+2)'($unsigned(count_l)) - (AB+2)'($unsigned(last_angle_left));
  assign rr = (AB+2)'($unsigned(count_r)) - (AB+2)'($unsigned(last_angle_right));

  // Wrap each count difference into one half turn either way.
  always_comb begin
    dl = rl;
    if (rl > HALF) dl = rl - FULL;
    else if (rl < -HALF) dl = rl + FULL;
    dr = rr;
    if (rr > HALF) dr = rr - FULL;
    else if (rr < -HALF) dr = rr + FULL;
  end
  assign dd = (AB+3)'(dl) - (AB+3)'(dr);

  assign tick_next = tick_count + 4'd1;
  assign upd       = (tick_next >= velocity_period);

  // Average with the stored estimate, floor halving, saturate to 32 bits.
  logic signed [39:0] vsum, vavg;
  logic signed [31:0] vsat;
  assign vsum = 40'(filtered_velocity) + 40'(prod);
  assign vavg = vsum >>> 1;
  always_comb begin
    if (vavg > 40'sd2147483647) vsat = 32'sh7FFFFFFF;
    else if (vavg < -40'sd2147483648) vsat = 32'sh80000000;
    else vsat = vavg[31:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_count        <= '0;
      last_angle_left   <= '0;
      last_angle_right  <= '0;
      filtered_velocity <= '0;
    end else if (cmd.vel_commit) begin
      if (upd) begin
        tick_count        <= '0;
        last_angle_left   <= count_l;
        last_angle_right  <= count_r;
        filtered_velocity <= vsat;
      end else begin
        tick_count <= tick_next;
      end
    end
  end

  // Output register.
  assign status.out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.vel_commit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.vel_commit) begin
      out_data.phase_a_left     <= pa_l;
      out_data.phase_b_left     <= pb_l;
      out_data.phase_c_left     <= pc_l;
      out_data.phase_a_right    <= pa_r;
      out_data.phase_b_right    <= pb_r;
      out_data.phase_c_right    <= pc_r;
      out_data.velocity         <= upd ? vsat : filtered_velocity;
      out_data.velocity_updated <= upd;
    end
  end

endmodule

// ===== rtl/dual_encoder_foc_voltage_and_velocity.sv =====
// ----------------------------------------------------------------------------
// Dual-encoder FOC voltage stage and velocity estimate
// Inverse Park and Clarke for two motors plus a filtered wheel velocity.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid / in_stall / in_data carries one request per tick:
//   two byte-swapped encoder words and two q-axis voltage commands.
//   Output channel out_valid / out_stall / out_data carries six saturated
//   Q8.8 phase voltages, the filtered velocity and an update flag.
//   Configuration is written through cfg_we / cfg_index / cfg_data while idle.
//   The block works on one request at a time and takes the next one in the
//   cycle after the result is registered. The length of each pass is set by
//   the single shared multiplier, used four times per motor pass and once for
//   velocity, plus the table read. A result held by out_stall blocks the
//   final step of the next request only; the input is taken meanwhile.
//   Reset restores the default registers and clears velocity state and
//   out_valid.
// ----------------------------------------------------------------------------
module dual_encoder_foc_voltage_and_velocity #(
  parameter int ANGLE_BITS       = 14,
  parameter int SINE_TABLE_DEPTH = 1024
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  defoc_pkg::in_t                      in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output defoc_pkg::out_t                     out_data,
  input  logic                                cfg_we,
  input  logic [defoc_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [defoc_pkg::CFG_DATA_BITS-1:0] cfg_data
);

  defoc_pkg::cmd_t    cmd;
  defoc_pkg::status_t status;

  // Controller.
  defoc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  // Datapath.
  defoc_dp #(
    .ANGLE_BITS       (ANGLE_BITS),
    .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .status    (status)
  );

endmodule

// ===== rtl/defoc_checker.sv =====
// ----------------------------------------------------------------------------
// defoc_checker: port-level checks
// Watches the top-level ports and is bound to the top level.
// ----------------------------------------------------------------------------
module defoc_checker (
  input logic            clk,
  input logic            rst,
  input logic            in_valid,
  input logic            in_stall,
  input logic            out_valid,
  input logic            out_stall,
  input defoc_pkg::out_t out_data
);

  // A held result stays valid and unchanged.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("held result changed");

  // One request at a time: the input closes after a request is taken.
  assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("second request taken while busy");

  // A result never appears in the cycle right after a request is taken.
  assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> !$rose(out_valid))
    else $error("result too early");

endmodule

bind dual_encoder_foc_voltage_and_velocity defoc_checker u_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the dual-encoder FOC voltage and velocity block
// Drives encoder and voltage requests with random gaps, stalls the result
// channel at random, and checks every result against an in-bench prediction
// of the phase voltages and the filtered velocity under several register
// settings.
// ----------------------------------------------------------------------------
module testbench;

  // Prediction of the block and the queue of phase results still owed.
  class foc_scoreboard;
    defoc_pkg::out_t owed_q[$];
    int          mismatches;
    logic [13:0] off_l, off_r, last_l, last_r;
    logic [4:0]  poles;
    logic [3:0]  period, ticks;
    logic [15:0] gain;
    longint      filt_vel;
    longint      sine_lut[1024];

    function new();
      longint unsigned x, x2, term;
      longint sum, v;
      int j, q;
      mismatches = 0;
      off_l = defoc_pkg::OFFSET_LEFT_RST; off_r = defoc_pkg::OFFSET_RIGHT_RST;
      poles = defoc_pkg::POLE_COUNT_RST; period = defoc_pkg::VEL_PERIOD_RST;
      gain = defoc_pkg::VEL_GAIN_RST;
      ticks = 0; last_l = 0; last_r = 0; filt_vel = 0;
      // Quarter-wave sine by Taylor series in Q30, folded over a full turn.
      for (int i = 0; i < 1024; i++) begin
        q = i / 256;
        j = i % 256;
        if (q % 2 == 1) j = 256 - j;
        x = longint'(j) * 64'd1686629713 / 256;
        x2 = (x * x) >> 30;
        term = x;
        sum = x;
        for (int k = 1; k <= 6; k++) begin
          term = ((term * x2) >> 30) / ((2 * k) * (2 * k + 1));
          if (k % 2 == 1) sum -= term;
          else sum += term;
        end
        v = (sum + 16384) >>> 15;
        if (v > 32767) v = 32767;
        if (v < 0) v = 0;
        sine_lut[i] = (q >= 2) ? -v : v;
      end
    endfunction

    function void write_reg(logic [2:0] idx, logic [15:0] val);
      case (idx)
        defoc_pkg::REG_OFFSET_LEFT:  off_l = val[13:0];
        defoc_pkg::REG_OFFSET_RIGHT: off_r = val[13:0];
        defoc_pkg::REG_POLE_COUNT:   poles = val[4:0];
        defoc_pkg::REG_VEL_PERIOD:   period = val[3:0];
        defoc_pkg::REG_VEL_GAIN:     gain = val;
        default: ;
      endcase
    endfunction

    function logic signed [15:0] clip16(longint v);
      if (v > 32767) return 16'sh7FFF;
      if (v < -32768) return 16'sh8000;
      return v[15:0];
    endfunction

    // Inverse Park with zero d-axis voltage, then inverse Clarke.
    function void motor_phases(logic [13:0] cnt, logic [13:0] off, longint vq,
                               output logic signed [15:0] pa, pb, pc);
      logic [13:0] diff, elec;
      int idx;
      longint alpha, beta, half_a, rb;
      diff = cnt - off;
      elec = 14'(diff * poles);
      idx = elec >> 4;
      alpha = -vq * sine_lut[idx];
      beta = vq * sine_lut[(idx + 256) % 1024];
      half_a = -alpha * 16384;
      rb = beta * 28378;
      pa = clip16((alpha + (64'sd1 <<< 14)) >>> 15);
      pb = clip16((half_a + rb + (64'sd1 <<< 29)) >>> 30);
      pc = clip16((half_a - rb + (64'sd1 <<< 29)) >>> 30);
    endfunction

    function longint wrap_counts(logic [13:0] now, logic [13:0] prev);
      longint d;
      d = longint'(now) - longint'(prev);
      if (d > 8192) d -= 16384;
      else if (d < -8192) d += 16384;
      return d;
    endfunction

    function void note_request(defoc_pkg::in_t req);
      defoc_pkg::out_t exp_r;
      logic [15:0] sl, sr;
      logic [13:0] cl, cr;
      longint sum;
      sl = {req.raw_left[7:0], req.raw_left[15:8]};
      sr = {req.raw_right[7:0], req.raw_right[15:8]};
      cl = sl[13:0];
      cr = sr[13:0];
      exp_r.velocity_updated = 1'b0;
      ticks = ticks + 4'd1;
      if (ticks >= period) begin
        sum = filt_vel + (wrap_counts(cl, last_l) - wrap_counts(cr, last_r))
              * longint'(gain);
        sum = sum >>> 1;
        if (sum > 64'sd2147483647) sum = 64'sd2147483647;
        if (sum < -64'sd2147483648) sum = -64'sd2147483648;
        filt_vel = sum;
        ticks = 0;
        last_l = cl;
        last_r = cr;
        exp_r.velocity_updated = 1'b1;
      end
      // The left command is negated before the transform.
      motor_phases(cl, off_l, -longint'(req.vq_left), exp_r.phase_a_left,
                   exp_r.phase_b_left, exp_r.phase_c_left);
      motor_phases(cr, off_r, longint'(req.vq_rt), exp_r.phase_a_right,
                   exp_r.phase_b_right, exp_r.phase_c_right);
      exp_r.velocity = filt_vel[31:0];
      owed_q.push_back(exp_r);
    endfunction

    function void check_result(defoc_pkg::out_t got);
      defoc_pkg::out_t exp_r;
      if (owed_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", got);
        return;
      end
      exp_r = owed_q.pop_front();
      if (got.phase_a_left !== exp_r.phase_a_left ||
          got.phase_b_left !== exp_r.phase_b_left ||
          got.phase_c_left !== exp_r.phase_c_left ||
          got.phase_a_right !== exp_r.phase_a_right ||
          got.phase_b_right !== exp_r.phase_b_right ||
          got.phase_c_right !== exp_r.phase_c_right ||
          got.velocity !== exp_r.velocity ||
          got.velocity_updated !== exp_r.velocity_updated) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: expected %h, got %h", exp_r, got);
      end
    endfunction
  endclass

  logic            clk = 1'b0;
  logic            rst = 1'b1;
  logic            in_valid = 1'b0;
  logic            in_stall;
  defoc_pkg::in_t  in_data = '0;
  logic            out_valid;
  logic            out_stall = 1'b0;
  defoc_pkg::out_t out_data;
  logic            cfg_we = 1'b0;
  logic [2:0]      cfg_index = '0;
  logic [15:0]     cfg_data = '0;
  foc_scoreboard   sb = new();
  bit              gaps_on = 1'b1;
  int              stall_left = 0;
  int              quiet_cycles = 0;
  logic [15:0]     enc_l = 0, enc_r = 0;

  dual_encoder_foc_voltage_and_velocity uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Mostly short gaps, a few long ones.
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (!gaps_on || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Result-side stall pattern.
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall <= 1'b1;
    end else begin
      stall_left <= gap_len();
      out_stall <= 1'b0;
    end
  end

  // Requests accepted and results returned.
  always @(posedge clk) begin
    if (!rst && in_valid && !in_stall) sb.note_request(in_data);
    if (!rst && out_valid && !out_stall) sb.check_result(out_data);
  end

  // Watchdog on cycles without any handshake.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= 3000) begin
      $display("testbench NOT OK");
      $finish;
    end
  end

  task automatic send_request(logic [15:0] rl, logic [15:0] rr,
                              logic [15:0] vl, logic [15:0] vr);
    int gap;
    in_valid <= 1'b1;
    in_data <= '{raw_left: rl, raw_right: rr, vq_left: vl, vq_rt: vr};
    do @(posedge clk); while (in_stall);
    gap = gap_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic write_cfg(logic [2:0] idx, logic [15:0] val);
    in_valid <= 1'b0;
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    sb.write_reg(idx, val);
    cfg_we <= 1'b0;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.owed_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // Encoder word: byte-swapped 16-bit value of a count that mostly moves slowly.
  function automatic logic [15:0] swap_bytes(logic [15:0] v);
    return {v[7:0], v[15:8]};
  endfunction

  task automatic random_requests(int n);
    logic [15:0] vl, vr;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 9) < 7) begin
        enc_l = enc_l + 16'($signed($urandom_range(0, 400)) - 200);
        enc_r = enc_r + 16'($signed($urandom_range(0, 400)) - 200);
      end else begin
        enc_l = 16'($urandom);
        enc_r = 16'($urandom);
      end
      vl = 16'($urandom);
      vr = 16'($urandom);
      if ($urandom_range(0, 15) == 0) vl = 16'h8000;
      if ($urandom_range(0, 15) == 0) vr = 16'h7FFF;
      send_request(swap_bytes(enc_l), swap_bytes(enc_r), vl, vr);
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed requests at reset settings: field extremes and full-scale commands.
    gaps_on = 1'b0;
    send_request(16'h0000, 16'h0000, 16'h0000, 16'h0000);
    send_request(16'hFFFF, 16'hFFFF, 16'h7FFF, 16'h7FFF);
    send_request(16'h00FF, 16'hFF00, 16'h8000, 16'h8000);
    send_request(16'hFF00, 16'h00FF, 16'h8001, 16'h0001);
    send_request(16'h5AA5, 16'hA55A, 16'hFFFF, 16'h8000);
    for (int i = 0; i < 8; i++)
      send_request(swap_bytes(16'(i * 1024)), swap_bytes(16'(16383 - i * 2000)),
                   16'h7FFF, 16'h8000);
    drain();

    // Extreme settings: every tick an update, full gain, largest pole count.
    write_cfg(defoc_pkg::REG_OFFSET_LEFT, 16'hFFFF);
    write_cfg(defoc_pkg::REG_OFFSET_RIGHT, 16'h0000);
    write_cfg(defoc_pkg::REG_POLE_COUNT, 16'd31);
    write_cfg(defoc_pkg::REG_VEL_PERIOD, 16'd0);
    write_cfg(defoc_pkg::REG_VEL_GAIN, 16'hFFFF);
    send_request(16'h0000, 16'h0020, 16'h8000, 16'h7FFF);
    send_request(16'h0020, 16'h0000, 16'h8000, 16'h7FFF);
    send_request(16'hFF3F, 16'h0000, 16'h7FFF, 16'h8000);
    send_request(16'h0000, 16'hFF3F, 16'h7FFF, 16'h8000);
    drain();

    // Zero pole pairs, zero gain, longest period, then a lowered period.
    write_cfg(defoc_pkg::REG_POLE_COUNT, 16'd0);
    write_cfg(defoc_pkg::REG_VEL_GAIN, 16'd0);
    write_cfg(defoc_pkg::REG_VEL_PERIOD, 16'd15);
    write_cfg(3'd5, 16'hFFFF);
    write_cfg(3'd7, 16'h1234);
    for (int i = 0; i < 6; i++)
      send_request(16'(i * 4099), 16'(i * 777), 16'h8000, 16'h7FFF);
    drain();
    write_cfg(defoc_pkg::REG_VEL_PERIOD, 16'd2);
    send_request(16'h1234, 16'h4321, 16'h0100, 16'hFF00);
    send_request(16'h2345, 16'h5432, 16'h0100, 16'hFF00);
    drain();

    // Random phases, each under a fresh register setting.
    gaps_on = 1'b1;
    for (int ph = 0; ph < 12; ph++) begin
      write_cfg(defoc_pkg::REG_OFFSET_LEFT, 16'($urandom));
      write_cfg(defoc_pkg::REG_OFFSET_RIGHT, 16'($urandom));
      write_cfg(defoc_pkg::REG_POLE_COUNT, 16'($urandom_range(0, 31)));
      write_cfg(defoc_pkg::REG_VEL_PERIOD, 16'($urandom_range(0, 15)));
      write_cfg(defoc_pkg::REG_VEL_GAIN, ph == 5 ? 16'hFFFF : 16'($urandom));
      if (ph == 3) write_cfg(3'd6, 16'($urandom));
      gaps_on = (ph % 4 != 2);
      random_requests(150);
      drain();
    end

    if (sb.mismatches == 0 && sb.owed_q.size() == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
